@@ hw/rtl/wsp_pkg.sv @@
package wsp_pkg;

  typedef enum logic [3:0] {
    PH_RIFF_TAG   = 4'd0,
    PH_RIFF_SIZE  = 4'd1,
    PH_WAVE_TAG   = 4'd2,
    PH_CHUNK_TAG  = 4'd3,
    PH_CHUNK_SIZE = 4'd4,
    PH_FMT_CODE   = 4'd5,
    PH_FMT_CHAN   = 4'd6,
    PH_FMT_RATE   = 4'd7,
    PH_FMT_MID    = 4'd8,
    PH_FMT_BITS   = 4'd9,
    PH_SKIP       = 4'd10,
    PH_DATA       = 4'd11,
    PH_IDLE       = 4'd12
  } phase_t;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [1:0] ERR_NOT_RIFF = 2'd0;
  localparam logic [1:0] ERR_NOT_WAVE = 2'd1;
  localparam logic [1:0] ERR_FORMAT   = 2'd2;
  localparam logic [1:0] ERR_RATE     = 2'd3;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam int unsigned RATE_W     = 18;
  localparam logic [RATE_W-1:0] RATE_RESET = 18'd16000;
  localparam logic [31:0] FMT_FIELD_BYTES = 32'd16;
  localparam logic [15:0] PCM_BITS        = 16'd16;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic signed [15:0] sample_value;
    logic [1:0]         error_code;
    logic [30:0]        sample_count;
    logic               last_of_run;
  } out_item_t;

  function automatic logic [2:0] field_len(input phase_t ph);
    logic [2:0] len;
    case (ph)
      PH_FMT_CODE, PH_FMT_CHAN, PH_FMT_BITS: len = 3'd2;
      PH_FMT_MID:                            len = 3'd6;
      default:                               len = 3'd4;
    endcase
    return len;
  endfunction

endpackage

@@ hw/rtl/wav_stream_parser_left_channel.sv @@
// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_ready    in_data  (in_item_t: one file byte + end flag)
// out_     output     out_valid / out_ready  out_data (out_item_t: sample, done or error)
// cfg_     input      cfg_wr_en              cfg_wr_data (required sample rate)
//
// One byte per cycle while the queue has room: a byte is registered, parsed in one
// pass and its zero to two results are written to an output queue of FIFO_DEPTH entries.
// An accepted byte passes the input register, then its results pass the output queue to out_.
// A registered byte advances only when the queue has two free entries, so a run of
// bytes that each yield two results drains at the output rate of one result per cycle
// while out_ready stays high. Synchronous active-low reset clears the parser and the
// queue; the rate register resets to 16000.
module wav_stream_parser_left_channel import wsp_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_wr_en,
  input  logic [RATE_W-1:0] cfg_wr_data
);

  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  logic              in_vld_r;
  in_item_t          in_item_r;
  logic [RATE_W-1:0] rate_r;
  logic              fire;
  logic              room;
  logic              pop;
  logic [1:0]        res_n;
  out_item_t         res0, res1;
  logic [CW-1:0]     q_cnt;

  assign room     = (q_cnt <= CW'(FIFO_DEPTH - 2));
  assign fire     = in_vld_r && room;
  assign in_ready = !in_vld_r || fire;
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      rate_r   <= RATE_RESET;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (cfg_wr_en) begin
        rate_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
  end

  wsp_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (fire),
    .item     (in_item_r),
    .req_rate (rate_r),
    .res_n    (res_n),
    .res0     (res0),
    .res1     (res1)
  );

  wsp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_n  (fire ? res_n : 2'd0),
    .push_d0 (res0),
    .push_d1 (res1),
    .pop     (pop),
    .q_vld   (out_valid),
    .q       (out_data),
    .cnt     (q_cnt)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt <= CW'(FIFO_DEPTH))
    else $error("output queue over capacity");

  a_pair_in_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last_of_run) |-> (q_cnt >= CW'(2)))
    else $error("non-final result without its partner queued");

  a_two_results: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res_n == 2'd2) |-> (!res0.last_of_run && res1.last_of_run))
    else $error("run end flag misplaced");

endmodule

@@ hw/rtl/wsp_fifo.sv @@
module wsp_fifo import wsp_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [1:0]                   push_n,
  input  out_item_t                    push_d0,
  input  out_item_t                    push_d1,
  input  logic                         pop,
  output logic                         q_vld,
  output out_item_t                    q,
  output logic [$clog2(DEPTH+1)-1:0]   cnt
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  out_item_t         mem_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt, wr_ptr_p1;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_comb begin
    wr_ptr_p1  = ptr_inc(wr_ptr_r);
    wr_ptr_nxt = wr_ptr_r;
    if (push_n == 2'd1) begin
      wr_ptr_nxt = wr_ptr_p1;
    end else if (push_n == 2'd2) begin
      wr_ptr_nxt = ptr_inc(wr_ptr_p1);
    end
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CW'(push_n) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= push_d0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_ptr_p1] <= push_d1;
    end
  end

  assign q_vld = (cnt_r != '0);
  assign q     = mem_r[rd_ptr_r];
  assign cnt   = cnt_r;

endmodule

@@ hw/rtl/wsp_core.sv @@
module wsp_core import wsp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  in_item_t          item,
  input  logic [RATE_W-1:0] req_rate,
  output logic [1:0]        res_n,
  output out_item_t         res0,
  output out_item_t         res1
);

  phase_t      ph_r, ph_nxt;
  logic [2:0]  idx_r, idx_nxt, idx_inc;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [31:0] left_r, left_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [1:0]  fbp_r, fbp_nxt, wrap;
  logic [30:0] cnt_r, cnt_nxt;

  logic        s_vld, t_vld, e_vld;
  logic [1:0]  t_kind, t_err, e_kind, e_err;
  logic [15:0] s_val;
  out_item_t   r_s, r_t, r_e;

  always_comb begin
    ph_nxt   = ph_r;
    idx_nxt  = idx_r;
    tag_nxt  = tag_r;
    len_nxt  = len_r;
    skip_nxt = skip_r;
    chan_nxt = chan_r;
    rate_nxt = rate_r;
    bits_nxt = bits_r;
    left_nxt = left_r;
    hold_nxt = hold_r;
    fbp_nxt  = fbp_r;
    cnt_nxt  = cnt_r;
    idx_inc  = idx_r + 3'd1;
    wrap     = (chan_r == 16'd2) ? 2'd3 : 2'd1;
    s_vld    = 1'b0;
    s_val    = {item.byte_value, hold_r};
    t_vld    = 1'b0;
    t_kind   = KIND_ERROR;
    t_err    = ERR_NOT_RIFF;
    e_vld    = 1'b0;
    e_kind   = KIND_ERROR;
    e_err    = ERR_NOT_RIFF;

    unique case (ph_r)
      PH_SKIP: begin
        skip_nxt = skip_r - 32'd1;
        if (skip_nxt == 32'd0) begin
          ph_nxt = PH_CHUNK_TAG;
        end
      end
      PH_DATA: begin
        if (fbp_r == 2'd0) begin
          hold_nxt = item.byte_value;
        end else if (fbp_r == 2'd1) begin
          cnt_nxt = cnt_r + 31'd1;
          s_vld   = 1'b1;
        end
        fbp_nxt  = (fbp_r + 2'd1) & wrap;
        left_nxt = left_r - 32'd1;
        if (left_nxt == 32'd0) begin
          t_vld  = 1'b1;
          t_kind = KIND_DONE;
          t_err  = ERR_NOT_RIFF;
          ph_nxt = PH_IDLE;
        end
      end
      PH_RIFF_TAG, PH_RIFF_SIZE, PH_WAVE_TAG, PH_CHUNK_TAG, PH_CHUNK_SIZE,
      PH_FMT_CODE, PH_FMT_CHAN, PH_FMT_RATE, PH_FMT_MID, PH_FMT_BITS: begin
        if (ph_r == PH_RIFF_TAG || ph_r == PH_WAVE_TAG || ph_r == PH_CHUNK_TAG) begin
          tag_nxt = {tag_r[23:0], item.byte_value};
        end
        len_nxt = {item.byte_value, len_r[31:8]};
        idx_nxt = idx_inc;
        if (idx_inc >= field_len(ph_r)) begin
          idx_nxt = 3'd0;
          unique case (ph_r)
            PH_RIFF_TAG: begin
              if (tag_nxt != TAG_RIFF) begin
                t_vld  = 1'b1;
                t_err  = ERR_NOT_RIFF;
                ph_nxt = PH_IDLE;
              end else begin
                ph_nxt = PH_RIFF_SIZE;
              end
            end
            PH_RIFF_SIZE: ph_nxt = PH_WAVE_TAG;
            PH_WAVE_TAG: begin
              if (tag_nxt != TAG_WAVE) begin
                t_vld  = 1'b1;
                t_err  = ERR_NOT_WAVE;
                ph_nxt = PH_IDLE;
              end else begin
                ph_nxt = PH_CHUNK_TAG;
              end
            end
            PH_CHUNK_TAG: ph_nxt = PH_CHUNK_SIZE;
            PH_CHUNK_SIZE: begin
              if (tag_r == TAG_FMT) begin
                skip_nxt = (len_nxt > FMT_FIELD_BYTES) ? len_nxt - FMT_FIELD_BYTES : 32'd0;
                ph_nxt   = PH_FMT_CODE;
              end else if (tag_r == TAG_DATA) begin
                left_nxt = len_nxt;
                if (len_nxt == 32'd0 || bits_r != PCM_BITS ||
                    (chan_r != 16'd1 && chan_r != 16'd2)) begin
                  t_vld  = 1'b1;
                  t_err  = ERR_FORMAT;
                  ph_nxt = PH_IDLE;
                end else if (rate_r != {{(32-RATE_W){1'b0}}, req_rate}) begin
                  t_vld  = 1'b1;
                  t_err  = ERR_RATE;
                  ph_nxt = PH_IDLE;
                end else begin
                  fbp_nxt = 2'd0;
                  ph_nxt  = PH_DATA;
                end
              end else begin
                skip_nxt = len_nxt;
                ph_nxt   = (len_nxt != 32'd0) ? PH_SKIP : PH_CHUNK_TAG;
              end
            end
            PH_FMT_CODE: ph_nxt = PH_FMT_CHAN;
            PH_FMT_CHAN: begin
              chan_nxt = len_nxt[31:16];
              ph_nxt   = PH_FMT_RATE;
            end
            PH_FMT_RATE: begin
              rate_nxt = len_nxt;
              ph_nxt   = PH_FMT_MID;
            end
            PH_FMT_MID: ph_nxt = PH_FMT_BITS;
            PH_FMT_BITS: begin
              bits_nxt = len_nxt[31:16];
              ph_nxt   = (skip_r != 32'd0) ? PH_SKIP : PH_CHUNK_TAG;
            end
            default: ph_nxt = PH_IDLE;
          endcase
        end
      end
      default: ph_nxt = PH_IDLE;
    endcase

    if (item.end_of_stream) begin
      unique case (ph_nxt)
        PH_RIFF_TAG: begin
          e_vld = 1'b1;
          e_err = ERR_NOT_RIFF;
        end
        PH_RIFF_SIZE, PH_WAVE_TAG: begin
          e_vld = 1'b1;
          e_err = ERR_NOT_WAVE;
        end
        PH_DATA: begin
          e_vld  = 1'b1;
          e_kind = KIND_DONE;
        end
        PH_IDLE: e_vld = 1'b0;
        default: begin
          e_vld = 1'b1;
          e_err = ERR_FORMAT;
        end
      endcase
    end
  end

  always_comb begin
    r_s = '{result_kind: KIND_SAMPLE, sample_value: s_val, error_code: ERR_NOT_RIFF,
            sample_count: cnt_nxt, last_of_run: 1'b0};
    r_t = '{result_kind: t_kind, sample_value: 16'sd0,
            error_code: (t_kind == KIND_ERROR) ? t_err : ERR_NOT_RIFF,
            sample_count: cnt_nxt, last_of_run: 1'b0};
    r_e = '{result_kind: e_kind, sample_value: 16'sd0,
            error_code: (e_kind == KIND_ERROR) ? e_err : ERR_NOT_RIFF,
            sample_count: cnt_nxt, last_of_run: 1'b0};
    res_n = 2'({1'b0, s_vld} + {1'b0, t_vld} + {1'b0, e_vld});
    res0  = s_vld ? r_s : (t_vld ? r_t : r_e);
    res1  = s_vld ? (t_vld ? r_t : r_e) : r_e;
    res0.last_of_run = (res_n == 2'd1);
    res1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (en && item.end_of_stream)) begin
      ph_r   <= PH_RIFF_TAG;
      idx_r  <= '0;
      tag_r  <= '0;
      len_r  <= '0;
      skip_r <= '0;
      chan_r <= '0;
      rate_r <= '0;
      bits_r <= '0;
      left_r <= '0;
      hold_r <= '0;
      fbp_r  <= '0;
      cnt_r  <= '0;
    end else if (en) begin
      ph_r   <= ph_nxt;
      idx_r  <= idx_nxt;
      tag_r  <= tag_nxt;
      len_r  <= len_nxt;
      skip_r <= skip_nxt;
      chan_r <= chan_nxt;
      rate_r <= rate_nxt;
      bits_r <= bits_nxt;
      left_r <= left_nxt;
      hold_r <= hold_nxt;
      fbp_r  <= fbp_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

@@ tb/sv/tb_wav_stream_parser_left_channel.sv @@
`timescale 1ns / 100ps

module tb_wav_stream_parser_left_channel;
  import wsp_pkg::*;

  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 12;
  localparam int CAP_BYTES     = 48;
  localparam logic [1:0] NO_ERROR = 2'd0;

  typedef struct {
    bit          has_fmt;
    bit          twice_fmt;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [15:0] bits;
    logic [31:0] fmt_len;
    bit          has_junk;
    logic [31:0] junk_len;
    logic [31:0] data_len;
    int          data_bytes;
    int          tail_bytes;
  } wav_spec_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;
  logic              cfg_wr_en = 1'b0;
  logic [RATE_W-1:0] cfg_wr_data = '0;

  bit        idle_en = 1'b1;
  int        items_sent = 0;
  int        mismatch_count = 0;
  int        stall_cycles = 0;
  logic [7:0] file_bytes[$];
  out_item_t pending_results[$];
  out_item_t step_results[$];
  out_item_t want_item;

  phase_t            parse_ph = PH_RIFF_TAG;
  logic [2:0]        field_idx = '0;
  logic [31:0]       tag_acc = '0;
  logic [31:0]       num_acc = '0;
  logic [31:0]       skip_left = '0;
  logic [15:0]       chan_cnt = '0;
  logic [31:0]       rate_decl = '0;
  logic [15:0]       bit_depth = '0;
  logic [31:0]       data_left = '0;
  logic [7:0]        low_hold = '0;
  logic [1:0]        frame_pos = '0;
  logic [30:0]       sample_total = '0;
  logic [RATE_W-1:0] rate_req = RATE_RESET;

  wav_stream_parser_left_channel DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= idle_en ? ($urandom_range(99) >= 37) : 1'b1;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("wav_stream_parser_left_channel verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected item kind %0d count %0d",
                                  out_data.result_kind, out_data.sample_count));
      end else begin
        want_item = pending_results.pop_front();
        if (out_data.result_kind !== want_item.result_kind)
          report_mismatch($sformatf("result_kind %0d, want %0d",
                                    out_data.result_kind, want_item.result_kind));
        if (out_data.sample_value !== want_item.sample_value)
          report_mismatch($sformatf("sample_value %0d, want %0d",
                                    out_data.sample_value, want_item.sample_value));
        if (out_data.error_code !== want_item.error_code)
          report_mismatch($sformatf("error_code %0d, want %0d",
                                    out_data.error_code, want_item.error_code));
        if (out_data.sample_count !== want_item.sample_count)
          report_mismatch($sformatf("sample_count %0d, want %0d",
                                    out_data.sample_count, want_item.sample_count));
        if (out_data.last_of_run !== want_item.last_of_run)
          report_mismatch($sformatf("last_of_run %0b, want %0b",
                                    out_data.last_of_run, want_item.last_of_run));
      end
    end
  end

  function automatic logic [2:0] field_width(input phase_t p);
    case (p)
      PH_FMT_CODE, PH_FMT_CHAN, PH_FMT_BITS: return 3'd2;
      PH_FMT_MID:                            return 3'd6;
      default:                               return 3'd4;
    endcase
  endfunction

  function automatic void push_result(input logic [1:0] kind, input logic [15:0] smp,
                                      input logic [1:0] err);
    out_item_t r;
    r.result_kind  = kind;
    r.sample_value = smp;
    r.error_code   = err;
    r.sample_count = sample_total;
    r.last_of_run  = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void abort_parse(input logic [1:0] err);
    push_result(KIND_ERROR, 16'd0, err);
    parse_ph = PH_IDLE;
  endfunction

  function automatic void clear_parser();
    parse_ph     = PH_RIFF_TAG;
    field_idx    = '0;
    tag_acc      = '0;
    num_acc      = '0;
    skip_left    = '0;
    chan_cnt     = '0;
    rate_decl    = '0;
    bit_depth    = '0;
    data_left    = '0;
    low_hold     = '0;
    frame_pos    = '0;
    sample_total = '0;
  endfunction

  function automatic void skip_or_next();
    parse_ph = (skip_left != 0) ? PH_SKIP : PH_CHUNK_TAG;
  endfunction

  function automatic void close_field();
    case (parse_ph)
      PH_RIFF_TAG: begin
        if (tag_acc != TAG_RIFF) abort_parse(ERR_NOT_RIFF);
        else parse_ph = PH_RIFF_SIZE;
      end
      PH_RIFF_SIZE: parse_ph = PH_WAVE_TAG;
      PH_WAVE_TAG: begin
        if (tag_acc != TAG_WAVE) abort_parse(ERR_NOT_WAVE);
        else parse_ph = PH_CHUNK_TAG;
      end
      PH_CHUNK_TAG: parse_ph = PH_CHUNK_SIZE;
      PH_CHUNK_SIZE: begin
        if (tag_acc == TAG_FMT) begin
          skip_left = (num_acc > FMT_FIELD_BYTES) ? num_acc - FMT_FIELD_BYTES : 32'd0;
          parse_ph  = PH_FMT_CODE;
        end else if (tag_acc == TAG_DATA) begin
          data_left = num_acc;
          if (num_acc == 0 || bit_depth != PCM_BITS ||
              (chan_cnt != 16'd1 && chan_cnt != 16'd2)) begin
            abort_parse(ERR_FORMAT);
          end else if (rate_decl != {14'd0, rate_req}) begin
            abort_parse(ERR_RATE);
          end else begin
            frame_pos = '0;
            parse_ph  = PH_DATA;
          end
        end else begin
          skip_left = num_acc;
          skip_or_next();
        end
      end
      PH_FMT_CODE: parse_ph = PH_FMT_CHAN;
      PH_FMT_CHAN: begin
        chan_cnt = num_acc[31:16];
        parse_ph = PH_FMT_RATE;
      end
      PH_FMT_RATE: begin
        rate_decl = num_acc;
        parse_ph  = PH_FMT_MID;
      end
      PH_FMT_MID: parse_ph = PH_FMT_BITS;
      PH_FMT_BITS: begin
        bit_depth = num_acc[31:16];
        skip_or_next();
      end
      default: parse_ph = PH_IDLE;
    endcase
  endfunction

  function automatic void take_data_byte(input logic [7:0] b);
    logic [1:0] wrap;
    wrap = (chan_cnt == 16'd2) ? 2'd3 : 2'd1;
    if (frame_pos == 2'd0) begin
      low_hold = b;
    end else if (frame_pos == 2'd1) begin
      sample_total = sample_total + 31'd1;
      push_result(KIND_SAMPLE, {b, low_hold}, NO_ERROR);
    end
    frame_pos = (frame_pos + 2'd1) & wrap;
    data_left = data_left - 32'd1;
    if (data_left == 0) begin
      push_result(KIND_DONE, 16'd0, NO_ERROR);
      parse_ph = PH_IDLE;
    end
  endfunction

  function automatic void predict_item(input in_item_t it);
    logic [7:0] b;
    b = it.byte_value;
    step_results.delete();
    if (parse_ph == PH_SKIP) begin
      skip_left = skip_left - 32'd1;
      if (skip_left == 0) parse_ph = PH_CHUNK_TAG;
    end else if (parse_ph == PH_DATA) begin
      take_data_byte(b);
    end else if (parse_ph < PH_SKIP) begin
      if (parse_ph == PH_RIFF_TAG || parse_ph == PH_WAVE_TAG || parse_ph == PH_CHUNK_TAG)
        tag_acc = {tag_acc[23:0], b};
      num_acc   = {b, num_acc[31:8]};
      field_idx = field_idx + 3'd1;
      if (field_idx >= field_width(parse_ph)) begin
        field_idx = '0;
        close_field();
      end
    end else begin
      parse_ph = PH_IDLE;
    end
    if (it.end_of_stream) begin
      if (parse_ph == PH_RIFF_TAG) abort_parse(ERR_NOT_RIFF);
      else if (parse_ph == PH_RIFF_SIZE || parse_ph == PH_WAVE_TAG) abort_parse(ERR_NOT_WAVE);
      else if (parse_ph == PH_DATA) push_result(KIND_DONE, 16'd0, NO_ERROR);
      else if (parse_ph != PH_IDLE) abort_parse(ERR_FORMAT);
      clear_parser();
    end
    if (step_results.size() > 0) step_results[step_results.size() - 1].last_of_run = 1'b1;
    foreach (step_results[i]) pending_results.push_back(step_results[i]);
  endfunction

  function automatic void push_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic void push_tag(input logic [31:0] t);
    for (int i = 3; i >= 0; i--) file_bytes.push_back(t[8*i +: 8]);
  endfunction

  function automatic void push_random(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(255));
      file_bytes.push_back(b);
    end
  endfunction

  function automatic int capped(input logic [31:0] n);
    return (n > CAP_BYTES) ? CAP_BYTES : int'(n);
  endfunction

  function automatic void push_fmt(input logic [15:0] chans, input logic [31:0] rate,
                                   input logic [15:0] bits, input logic [31:0] len);
    push_tag(TAG_FMT);
    push_le(len, 4);
    push_le(32'd1, 2);
    push_le({16'd0, chans}, 2);
    push_le(rate, 4);
    push_random(6);
    push_le({16'd0, bits}, 2);
    push_random((len > FMT_FIELD_BYTES) ? capped(len - FMT_FIELD_BYTES) : 0);
  endfunction

  function automatic void build_wav(input wav_spec_t s);
    file_bytes.delete();
    push_tag(TAG_RIFF);
    push_le($urandom, 4);
    push_tag(TAG_WAVE);
    if (s.has_junk) begin
      push_tag(32'h4C49_5354);
      push_le(s.junk_len, 4);
      push_random(capped(s.junk_len));
    end
    if (s.twice_fmt) push_fmt(16'($urandom_range(65535)), $urandom, 16'd8, FMT_FIELD_BYTES);
    if (s.has_fmt) push_fmt(s.chans, s.rate, s.bits, s.fmt_len);
    push_tag(TAG_DATA);
    push_le(s.data_len, 4);
    push_random(s.data_bytes);
    push_random(s.tail_bytes);
  endfunction

  function automatic wav_spec_t base_spec();
    wav_spec_t s;
    s.has_fmt    = 1'b1;
    s.twice_fmt  = 1'b0;
    s.chans      = 16'd1;
    s.rate       = {14'd0, rate_req};
    s.bits       = PCM_BITS;
    s.fmt_len    = FMT_FIELD_BYTES;
    s.has_junk   = 1'b0;
    s.junk_len   = '0;
    s.data_len   = 32'd4;
    s.data_bytes = 4;
    s.tail_bytes = 0;
    return s;
  endfunction

  function automatic wav_spec_t random_spec();
    wav_spec_t s;
    int r;
    s = base_spec();
    s.has_fmt   = ($urandom_range(99) < 95);
    s.twice_fmt = ($urandom_range(99) < 10);
    r = $urandom_range(19);
    s.chans = (r == 0) ? 16'($urandom_range(65535)) :
              (r == 1) ? 16'd3 : (r < 11) ? 16'd1 : 16'd2;
    if ($urandom_range(19) == 0) s.bits = 16'($urandom_range(32));
    r = $urandom_range(19);
    if (r == 0) s.rate = $urandom;
    else if (r == 1) s.rate = {14'd0, rate_req} + 32'd1;
    r = $urandom_range(9);
    if (r == 0) s.fmt_len = $urandom_range(15);
    else if (r < 3) s.fmt_len = FMT_FIELD_BYTES + $urandom_range(1, 8);
    s.has_junk = ($urandom_range(99) < 30);
    s.junk_len = ($urandom_range(9) == 0) ? $urandom : $urandom_range(9);
    r = $urandom_range(19);
    s.data_len = (r == 0) ? 32'd0 : (r == 1) ? $urandom : $urandom_range(1, 24);
    if (s.data_len > 24) s.data_bytes = $urandom_range(24);
    else if ($urandom_range(99) < 80) s.data_bytes = int'(s.data_len);
    else s.data_bytes = $urandom_range(int'(s.data_len));
    s.tail_bytes = $urandom_range(3);
    return s;
  endfunction

  task automatic send_item(input in_item_t it);
    while (idle_en && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(it);
  endtask

  task automatic send_file();
    in_item_t it;
    for (int i = 0; i < file_bytes.size(); i++) begin
      it.byte_value    = file_bytes[i];
      it.end_of_stream = (i == file_bytes.size() - 1);
      send_item(it);
    end
    items_sent += file_bytes.size();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_rate(input logic [RATE_W-1:0] v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    rate_req = v;
  endtask

  task automatic test_tag_checks();
    file_bytes = '{8'hFF};
    send_file();
    file_bytes.delete();
    push_tag(TAG_RIFF ^ 32'h0000_001E);
    push_le(32'h0, 1);
    send_file();
    file_bytes.delete();
    push_tag(TAG_RIFF);
    push_le(32'hFFFF_FFFF, 4);
    push_tag(TAG_WAVE ^ 32'h0000_001D);
    push_le(32'hFF, 1);
    send_file();
  endtask

  task automatic test_early_end();
    wav_spec_t s;
    file_bytes.delete();
    push_tag(TAG_RIFF);
    push_le(32'h0, 2);
    send_file();
    file_bytes.delete();
    push_tag(TAG_RIFF);
    push_le(32'h0, 4);
    push_tag(TAG_WAVE);
    push_le(32'h6164, 2);
    send_file();
    s = base_spec();
    s.data_len   = 32'd10;
    s.data_bytes = 5;
    build_wav(s);
    send_file();
  endtask

  task automatic test_mono_samples();
    wav_spec_t s;
    int base;
    s = base_spec();
    s.data_len   = 32'd5;
    s.data_bytes = 5;
    s.tail_bytes = 2;
    build_wav(s);
    base = file_bytes.size() - 7;
    file_bytes[base]     = 8'h00;
    file_bytes[base + 1] = 8'h80;
    file_bytes[base + 2] = 8'hFF;
    file_bytes[base + 3] = 8'h7F;
    file_bytes[base + 4] = 8'h55;
    send_file();
  endtask

  task automatic test_stereo_chunk_walk();
    wav_spec_t s;
    s = base_spec();
    s.chans      = 16'd2;
    s.has_junk   = 1'b1;
    s.junk_len   = 32'd3;
    s.twice_fmt  = 1'b1;
    s.fmt_len    = 32'd14;
    s.data_len   = 32'd7;
    s.data_bytes = 7;
    build_wav(s);
    send_file();
    s.twice_fmt  = 1'b0;
    s.junk_len   = 32'd0;
    s.fmt_len    = 32'd20;
    s.data_len   = 32'd9;
    s.data_bytes = 6;
    build_wav(s);
    send_file();
  endtask

  task automatic test_format_checks();
    wav_spec_t s;
    s = base_spec();
    s.bits = 16'd8;
    build_wav(s);
    send_file();
    s = base_spec();
    s.chans = 16'd3;
    build_wav(s);
    send_file();
    s = base_spec();
    s.has_fmt = 1'b0;
    build_wav(s);
    send_file();
    s = base_spec();
    s.data_len   = 32'd0;
    s.data_bytes = 0;
    s.tail_bytes = 2;
    build_wav(s);
    send_file();
    s = base_spec();
    s.rate = s.rate + 32'd1;
    build_wav(s);
    send_file();
  endtask

  task automatic test_rate_register();
    wav_spec_t s;
    set_rate(18'd8000);
    build_wav(base_spec());
    send_file();
    set_rate(18'd192000);
    s = base_spec();
    s.chans      = 16'd2;
    s.data_len   = 32'd8;
    s.data_bytes = 8;
    build_wav(s);
    send_file();
    s.rate = 32'd8000;
    build_wav(s);
    send_file();
  endtask

  task automatic test_random_streams(input logic [RATE_W-1:0] rate, input bit calm,
                                     input int budget);
    int first;
    int pick;
    set_rate(rate);
    idle_en <= !calm;
    first = items_sent;
    while (items_sent - first < budget) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        build_wav(random_spec());
      end else if (pick < 85) begin
        build_wav(random_spec());
        file_bytes = file_bytes[0:$urandom_range(file_bytes.size() - 1)];
      end else begin
        file_bytes.delete();
        if ($urandom_range(1)) push_tag(TAG_RIFF);
        push_random($urandom_range(1, 12));
      end
      send_file();
    end
    idle_en <= 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_tag_checks();
    test_early_end();
    test_mono_samples();
    test_stereo_chunk_walk();
    test_format_checks();
    test_rate_register();
    test_random_streams(18'd8000, 1'b0, 100);
    test_random_streams(18'd192000, 1'b1, 100);
    test_random_streams(RATE_W'($urandom_range(192000, 8000)), 1'b0, 100);
    test_random_streams(RATE_RESET, 1'b0, 100);
    wait_drained();
    if (mismatch_count == 0) begin
      $display("wav_stream_parser_left_channel verification clean");
    end else begin
      $display("wav_stream_parser_left_channel verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/wsp_pkg.sv
hw/rtl/wsp_fifo.sv
hw/rtl/wsp_core.sv
hw/rtl/wav_stream_parser_left_channel.sv
tb/sv/tb_wav_stream_parser_left_channel.sv
